>>> rtl/usbphy_pkg.sv
`default_nettype none

package usbphy_pkg;

  localparam int DataW = 32;
  localparam int OffW  = 13;
  localparam int SizeW = 3;
  localparam int ErrW  = 2;

  localparam logic [SizeW-1:0] SIZE_WORD = 3'd4;

  localparam logic [OffW-1:0] OFF_PWD  = 13'h000;
  localparam logic [OffW-1:0] OFF_TX   = 13'h010;
  localparam logic [OffW-1:0] OFF_RX   = 13'h020;
  localparam logic [OffW-1:0] OFF_CTRL = 13'h030;
  localparam logic [OffW-1:0] OFF_STAT = 13'h040;
  localparam logic [OffW-1:0] OFF_DBG  = 13'h050;
  localparam logic [OffW-1:0] OFF_DBG0 = 13'h060;
  localparam logic [OffW-1:0] OFF_DBG1 = 13'h070;
  localparam logic [OffW-1:0] OFF_VER  = 13'h080;

  localparam logic [DataW-1:0] MASK_PWD  = 32'h001F7C00;
  localparam logic [DataW-1:0] MASK_TX   = 32'h1FAF2F8F;
  localparam logic [DataW-1:0] MASK_RX   = 32'h00400033;
  localparam logic [DataW-1:0] MASK_CTRL = 32'hD0003EBF;
  localparam logic [DataW-1:0] MASK_DBG  = 32'h7F1F1F3F;
  localparam logic [DataW-1:0] MASK_DBG1 = 32'h0000700F;

  localparam logic [DataW-1:0] RST_PWD  = 32'h001F7C00;
  localparam logic [DataW-1:0] RST_TX   = 32'h10060607;
  localparam logic [DataW-1:0] RST_RX   = 32'h00000000;
  localparam logic [DataW-1:0] RST_CTRL = 32'hC0000001;
  localparam logic [DataW-1:0] RST_DBG  = 32'h7F180000;
  localparam logic [DataW-1:0] RST_DBG1 = 32'h00001000;

  localparam logic [DataW-1:0] DBG0_VALUE = 32'h0000900D;
  localparam logic [DataW-1:0] VER_VALUE  = 32'h03000000;

  localparam int BIT_SOFTRST = 31;
  localparam int BIT_SUSPEND = 29;
  localparam int BIT_OTGID   = 8;

  typedef enum logic [ErrW-1:0] {
    ERR_OK       = 2'd0,
    ERR_SIZE     = 2'd1,
    ERR_UNMAPPED = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SET    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_TOGGLE = 2'd3
  } alias_op_t;

  typedef enum logic [3:0] {
    RD_NONE,
    RD_PWD,
    RD_TX,
    RD_RX,
    RD_CTRL,
    RD_STAT,
    RD_DBG,
    RD_DBG0,
    RD_DBG1,
    RD_VER
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_PWD,
    WR_TX,
    WR_RX,
    WR_CTRL,
    WR_STAT,
    WR_DBG,
    WR_DBG1
  } wr_sel_t;

  typedef struct packed {
    err_t      err;
    rd_sel_t   rd_sel;
    wr_sel_t   wr_sel;
    alias_op_t op;
  } dec_t;

  function automatic logic [DataW-1:0] alias_apply(input logic [DataW-1:0] cur,
                                                   input logic [DataW-1:0] val,
                                                   input alias_op_t op);
    logic [DataW-1:0] res;
    case (op)
      OP_WRITE: res = val;
      OP_SET:   res = cur | val;
      OP_CLEAR: res = cur & ~val;
      default:  res = cur ^ val;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/usbphy_decode.sv
`default_nettype none

module usbphy_decode
  import usbphy_pkg::*;
(
  input  wire logic             mode,
  input  wire logic [OffW-1:0]  offset,
  input  wire logic [SizeW-1:0] access_size,
  output dec_t                  dec
);

  logic [OffW-1:0] base;
  rd_sel_t         rd_sel;
  wr_sel_t         wr_sel;

  assign base = {offset[OffW-1:4], 2'b00, offset[1:0]};

  always_comb begin
    unique case (offset)
      OFF_PWD:  rd_sel = RD_PWD;
      OFF_TX:   rd_sel = RD_TX;
      OFF_RX:   rd_sel = RD_RX;
      OFF_CTRL: rd_sel = RD_CTRL;
      OFF_STAT: rd_sel = RD_STAT;
      OFF_DBG:  rd_sel = RD_DBG;
      OFF_DBG0: rd_sel = RD_DBG0;
      OFF_DBG1: rd_sel = RD_DBG1;
      OFF_VER:  rd_sel = RD_VER;
      default:  rd_sel = RD_NONE;
    endcase
  end

  always_comb begin
    unique case (base)
      OFF_PWD:  wr_sel = WR_PWD;
      OFF_TX:   wr_sel = WR_TX;
      OFF_RX:   wr_sel = WR_RX;
      OFF_CTRL: wr_sel = WR_CTRL;
      OFF_DBG:  wr_sel = WR_DBG;
      OFF_DBG1: wr_sel = WR_DBG1;
      default:  wr_sel = (offset == OFF_STAT) ? WR_STAT : WR_NONE;
    endcase
  end

  always_comb begin
    dec.op     = alias_op_t'(offset[3:2]);
    dec.rd_sel = RD_NONE;
    dec.wr_sel = WR_NONE;
    dec.err    = ERR_OK;
    if (access_size != SIZE_WORD) begin
      dec.err = ERR_SIZE;
    end else if (!mode) begin
      dec.rd_sel = rd_sel;
      if (rd_sel == RD_NONE) begin
        dec.err = ERR_UNMAPPED;
      end
    end else begin
      dec.wr_sel = wr_sel;
      if (wr_sel == WR_NONE) begin
        dec.err = ERR_UNMAPPED;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/usbphy_regs.sv
`default_nettype none

module usbphy_regs
  import usbphy_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire dec_t             dec,
  input  wire logic [DataW-1:0] write_data,
  output logic      [DataW-1:0] rdata
);

  logic [DataW-1:0] power_down;
  logic [DataW-1:0] transmit;
  logic [DataW-1:0] receive;
  logic [DataW-1:0] control;
  logic             otg_id;
  logic [DataW-1:0] debug;
  logic [DataW-1:0] debug_one;
  logic [DataW-1:0] control_next;
  logic [DataW-1:0] control_view;

  assign control_next = alias_apply(control, write_data & MASK_CTRL, dec.op);

  always_ff @(posedge clk) begin
    if (rst) begin
      power_down <= RST_PWD;
      transmit   <= RST_TX;
      receive    <= RST_RX;
      control    <= RST_CTRL;
      otg_id     <= 1'b0;
      debug      <= RST_DBG;
      debug_one  <= RST_DBG1;
    end else if (en) begin
      unique case (dec.wr_sel)
        WR_PWD:  power_down <= alias_apply(power_down, write_data & MASK_PWD, dec.op);
        WR_TX:   transmit   <= alias_apply(transmit, write_data & MASK_TX, dec.op);
        WR_RX:   receive    <= alias_apply(receive, write_data & MASK_RX, dec.op);
        WR_CTRL: begin
          if (control_next[BIT_SOFTRST]) begin
            power_down <= RST_PWD;
            transmit   <= RST_TX;
            receive    <= RST_RX;
            control    <= RST_CTRL;
          end else begin
            control <= control_next;
          end
        end
        WR_STAT: otg_id    <= write_data[BIT_OTGID];
        WR_DBG:  debug     <= alias_apply(debug, write_data & MASK_DBG, dec.op);
        WR_DBG1: debug_one <= alias_apply(debug_one, write_data & MASK_DBG1, dec.op);
        default: ;
      endcase
    end
  end

  always_comb begin
    control_view              = control;
    control_view[BIT_SUSPEND] = ((power_down & MASK_PWD) != MASK_PWD);
  end

  always_comb begin
    rdata = '0;
    unique case (dec.rd_sel)
      RD_PWD:  rdata = power_down;
      RD_TX:   rdata = transmit;
      RD_RX:   rdata = receive;
      RD_CTRL: rdata = control_view;
      RD_STAT: rdata[BIT_OTGID] = otg_id;
      RD_DBG:  rdata = debug;
      RD_DBG0: rdata = DBG0_VALUE;
      RD_DBG1: rdata = debug_one;
      RD_VER:  rdata = VER_VALUE;
      default: rdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/usb_phy_register_block.sv
// Register block of a USB PHY with a start/busy command port. Busy stays low, so a new
// access may be started in every cycle. Each access is captured in an input register,
// decoded and applied in the following cycle, and its read data and error code appear on
// the result ports from an output register with done high for one cycle. Results cannot
// be held off and must be taken in that cycle. A write becomes visible to the next
// access, even one started in the cycle right after it.
`default_nettype none

module usb_phy_register_block
  import usbphy_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             mode,
  input  wire logic [OffW-1:0]  offset,
  input  wire logic [DataW-1:0] write_data,
  input  wire logic [SizeW-1:0] access_size,
  output logic                  done,
  output logic      [DataW-1:0] read_data,
  output logic      [ErrW-1:0]  error_code
);

  logic             in_valid;
  logic             mode_q;
  logic [OffW-1:0]  offset_q;
  logic [DataW-1:0] wdata_q;
  logic [SizeW-1:0] size_q;
  dec_t             dec;
  logic [DataW-1:0] rdata;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    mode_q   <= mode;
    offset_q <= offset;
    wdata_q  <= write_data;
    size_q   <= access_size;
  end

  usbphy_decode u_decode (
    .mode        (mode_q),
    .offset      (offset_q),
    .access_size (size_q),
    .dec         (dec)
  );

  usbphy_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .en         (in_valid),
    .dec        (dec),
    .write_data (wdata_q),
    .rdata      (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    read_data  <= rdata;
    error_code <= dec.err;
  end

endmodule

`default_nettype wire

>>> rtl/usbphy_checker.sv
`default_nettype none

module usbphy_checker
  import usbphy_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             mode,
  input wire logic             done,
  input wire logic [DataW-1:0] read_data,
  input wire logic [ErrW-1:0]  error_code
);

  // Every started beat is answered by done.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("started beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a started beat");

  a_err_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (error_code == ERR_OK || error_code == ERR_SIZE ||
              error_code == ERR_UNMAPPED))
    else $error("illegal error code");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    done && (error_code != ERR_OK || $past(mode, 2)) |-> read_data == '0)
    else $error("read data not zero on write or error");

endmodule

bind usb_phy_register_block usbphy_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .mode       (mode),
  .done       (done),
  .read_data  (read_data),
  .error_code (error_code)
);

`default_nettype wire

>>> bench/usb_phy_register_block_test.sv
module usb_phy_register_block_test
  import usbphy_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 3;
  localparam int RANDOM_ACCESSES = 1525;
  localparam int DRAIN_EVERY = 250;
  localparam int TAIL_CYCLES = 8;
  localparam int QUIET_LIMIT = 1000;
  localparam int REPORT_LIMIT = 10;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam logic [OffW-1:0] ALIAS_BITS = 13'h00C;

  typedef struct packed {
    logic             mode;
    logic [OffW-1:0]  offset;
    logic [DataW-1:0] write_data;
    logic [SizeW-1:0] access_size;
    logic             drain;
  } access_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    err_t             error_code;
  } reply_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             mode = MODE_READ;
  logic [OffW-1:0]  offset = '0;
  logic [DataW-1:0] write_data = '0;
  logic [SizeW-1:0] access_size = SIZE_WORD;
  logic             busy;
  logic             done;
  logic [DataW-1:0] read_data;
  logic [ErrW-1:0]  error_code;

  access_t access_queue[$];
  reply_t  replies_due[$];
  access_t in_flight;
  int      failures = 0;
  int      gap_left = 0;
  int      burst_left = 1;
  int      quiet_cycles = 0;

  logic [DataW-1:0] pwd_q, tx_q, rx_q, ctrl_q, dbg_q, dbg1_q;
  logic             otg_id_q;

  usb_phy_register_block i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .offset      (offset),
    .write_data  (write_data),
    .access_size (access_size),
    .done        (done),
    .read_data   (read_data),
    .error_code  (error_code)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void note_failure(input string what);
    if (failures < REPORT_LIMIT) begin
      $display("%0t: %s", $time, what);
    end
    failures++;
  endfunction

  function automatic void reload_phy_regs();
    pwd_q  = RST_PWD;
    tx_q   = RST_TX;
    rx_q   = RST_RX;
    ctrl_q = RST_CTRL;
  endfunction

  function automatic logic [DataW-1:0] alias_result(input logic [DataW-1:0] cur,
                                                    input logic [DataW-1:0] val,
                                                    input alias_op_t op);
    case (op)
      OP_WRITE: return val;
      OP_SET:   return cur | val;
      OP_CLEAR: return cur & ~val;
      default:  return cur ^ val;
    endcase
  endfunction

  // Updates the register image with one access and returns the reply it earns.
  function automatic reply_t apply_access(input access_t a);
    reply_t           r;
    alias_op_t        op;
    logic [OffW-1:0]  base;
    logic [DataW-1:0] ctrl_view;
    r.read_data = '0;
    r.error_code = ERR_OK;
    op = alias_op_t'(a.offset[3:2]);
    base = a.offset & ~ALIAS_BITS;
    if (a.access_size != SIZE_WORD) begin
      r.error_code = ERR_SIZE;
    end else if (a.mode == MODE_READ) begin
      case (a.offset)
        OFF_PWD:  r.read_data = pwd_q;
        OFF_TX:   r.read_data = tx_q;
        OFF_RX:   r.read_data = rx_q;
        OFF_CTRL: begin
          ctrl_view = ctrl_q;
          ctrl_view[BIT_SUSPEND] = ((pwd_q & MASK_PWD) != MASK_PWD);
          r.read_data = ctrl_view;
        end
        OFF_STAT: begin
          r.read_data = '0;
          r.read_data[BIT_OTGID] = otg_id_q;
        end
        OFF_DBG:  r.read_data = dbg_q;
        OFF_DBG0: r.read_data = DBG0_VALUE;
        OFF_DBG1: r.read_data = dbg1_q;
        OFF_VER:  r.read_data = VER_VALUE;
        default:  r.error_code = ERR_UNMAPPED;
      endcase
    end else begin
      case (base)
        OFF_PWD:  pwd_q = alias_result(pwd_q, a.write_data & MASK_PWD, op);
        OFF_TX:   tx_q = alias_result(tx_q, a.write_data & MASK_TX, op);
        OFF_RX:   rx_q = alias_result(rx_q, a.write_data & MASK_RX, op);
        OFF_CTRL: begin
          ctrl_q = alias_result(ctrl_q, a.write_data & MASK_CTRL, op);
          if (ctrl_q[BIT_SOFTRST]) begin
            reload_phy_regs();
          end
        end
        OFF_DBG:  dbg_q = alias_result(dbg_q, a.write_data & MASK_DBG, op);
        OFF_DBG1: dbg1_q = alias_result(dbg1_q, a.write_data & MASK_DBG1, op);
        default: begin
          if (a.offset == OFF_STAT) begin
            otg_id_q = a.write_data[BIT_OTGID];
          end else begin
            r.error_code = ERR_UNMAPPED;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic access_t beat(input logic m, input logic [OffW-1:0] off,
                                   input logic [DataW-1:0] data,
                                   input logic [SizeW-1:0] size);
    access_t a;
    a.mode = m;
    a.offset = off;
    a.write_data = data;
    a.access_size = size;
    a.drain = 1'b0;
    return a;
  endfunction

  // Most accesses hit mapped registers with legal aliases; a few are wrong-size or land
  // anywhere in the window. Control writes mostly keep soft reset clear so the other
  // registers can drift away from their reset values.
  function automatic access_t random_access(input logic drain);
    access_t   a;
    alias_op_t op;
    op = alias_op_t'($urandom_range(0, 3));
    a.drain = drain;
    a.access_size = ($urandom_range(0, 11) == 0) ? SizeW'($urandom_range(0, 7)) : SIZE_WORD;
    case ($urandom_range(0, 7))
      0:       a.write_data = '0;
      1:       a.write_data = '1;
      default: a.write_data = $urandom;
    endcase
    if ($urandom_range(0, 15) == 0) begin
      a.mode = 1'($urandom_range(0, 1));
      a.offset = OffW'($urandom_range(0, 8191));
    end else if ($urandom_range(0, 1) == 0) begin
      a.mode = MODE_READ;
      case ($urandom_range(0, 8))
        0:       a.offset = OFF_PWD;
        1:       a.offset = OFF_TX;
        2:       a.offset = OFF_RX;
        3:       a.offset = OFF_CTRL;
        4:       a.offset = OFF_STAT;
        5:       a.offset = OFF_DBG;
        6:       a.offset = OFF_DBG0;
        7:       a.offset = OFF_DBG1;
        default: a.offset = OFF_VER;
      endcase
    end else begin
      a.mode = MODE_WRITE;
      case ($urandom_range(0, 6))
        0:       a.offset = OFF_PWD;
        1:       a.offset = OFF_TX;
        2:       a.offset = OFF_RX;
        3:       a.offset = OFF_CTRL;
        4:       a.offset = OFF_DBG;
        5:       a.offset = OFF_DBG1;
        default: a.offset = OFF_STAT;
      endcase
      if (a.offset != OFF_STAT || $urandom_range(0, 3) == 0) begin
        a.offset[3:2] = op;
      end
      if ((a.offset & ~ALIAS_BITS) == OFF_CTRL && $urandom_range(0, 3) != 0) begin
        a.write_data[BIT_SOFTRST] = (op == OP_CLEAR);
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin : driver
    access_t nxt;
    logic    fired;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
      burst_left = $urandom_range(1, 40);
    end else begin
      fired = start && !busy;
      if (fired) begin
        replies_due.push_back(apply_access(in_flight));
      end
      if (!start || fired) begin
        if (gap_left == 0 && access_queue.size() != 0 &&
            !(access_queue[0].drain && replies_due.size() != 0)) begin
          nxt = access_queue.pop_front();
          in_flight = nxt;
          start <= 1'b1;
          mode <= nxt.mode;
          offset <= nxt.offset;
          write_data <= nxt.write_data;
          access_size <= nxt.access_size;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          if (gap_left != 0) begin
            gap_left--;
          end
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    reply_t want;
    if (!rst && done === 1'b1) begin
      if (replies_due.size() == 0) begin
        note_failure($sformatf("unexpected beat: read_data %h error_code %0d",
                               read_data, error_code));
      end else begin
        want = replies_due.pop_front();
        if (read_data !== want.read_data || error_code !== want.error_code) begin
          note_failure($sformatf("mismatch: read_data %h error_code %0d, expected %h %0d",
                                 read_data, error_code, want.read_data, want.error_code));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done === 1'b1) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin : stimulus
    access_t a;
    pwd_q = '0;
    tx_q = '0;
    rx_q = '0;
    ctrl_q = '0;
    reload_phy_regs();
    otg_id_q = 1'b0;
    dbg_q = RST_DBG;
    dbg1_q = RST_DBG1;

    access_queue.push_back(beat(MODE_READ, OFF_PWD, '0, SIZE_WORD));
    access_queue.push_back(beat(MODE_READ, OFF_TX, '1, SIZE_WORD));
    access_queue.push_back(beat(MODE_READ, OFF_RX, '0, SIZE_WORD));
    access_queue.push_back(beat(MODE_READ, OFF_CTRL, '0, SIZE_WORD));
    access_queue.push_back(beat(MODE_READ, OFF_STAT, '0, SIZE_WORD));
    access_queue.push_back(beat(MODE_READ, OFF_DBG, '0, SIZE_WORD));
    access_queue.push_back(beat(MODE_READ, OFF_DBG0, '0, SIZE_WORD));
    access_queue.push_back(beat(MODE_READ, OFF_DBG1, '0, SIZE_WORD));
    access_queue.push_back(beat(MODE_READ, OFF_VER, '0, SIZE_WORD));
    // Size is checked before the offset, and a wrong-size write leaves state alone.
    access_queue.push_back(beat(MODE_READ, OFF_CTRL, '0, 3'd3));
    access_queue.push_back(beat(MODE_WRITE, OFF_PWD, '1, 3'd0));
    access_queue.push_back(beat(MODE_READ, 13'h1FFF, '0, 3'd7));
    access_queue.push_back(beat(MODE_READ, OFF_PWD | ALIAS_BITS, '0, SIZE_WORD));
    access_queue.push_back(beat(MODE_WRITE, OFF_DBG0, '1, SIZE_WORD));
    access_queue.push_back(beat(MODE_WRITE, OFF_VER, '1, SIZE_WORD));
    access_queue.push_back(beat(MODE_WRITE, OFF_STAT | 13'h004, '1, SIZE_WORD));
    access_queue.push_back(beat(MODE_WRITE, OFF_STAT, '1, SIZE_WORD));
    access_queue.push_back(beat(MODE_READ, OFF_STAT, '0, SIZE_WORD));
    access_queue.push_back(beat(MODE_WRITE, OFF_CTRL | {9'd0, OP_CLEAR, 2'b00}, 32'hFFFF_FFFF,
                                SIZE_WORD));
    access_queue.push_back(beat(MODE_WRITE, OFF_PWD | {9'd0, OP_CLEAR, 2'b00}, '1, SIZE_WORD));
    access_queue.push_back(beat(MODE_READ, OFF_CTRL, '0, SIZE_WORD));
    access_queue.push_back(beat(MODE_WRITE, OFF_TX | {9'd0, OP_SET, 2'b00}, '1, SIZE_WORD));
    access_queue.push_back(beat(MODE_WRITE, OFF_DBG | {9'd0, OP_TOGGLE, 2'b00}, '1, SIZE_WORD));
    access_queue.push_back(beat(MODE_WRITE, OFF_CTRL, '1, SIZE_WORD));
    access_queue.push_back(beat(MODE_READ, OFF_PWD, '0, SIZE_WORD));

    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      a = random_access(i % DRAIN_EVERY == 0);
      access_queue.push_back(a);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (access_queue.size() != 0 || start || replies_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    for (int i = 0; i < replies_due.size(); i++) begin
      note_failure($sformatf("missing beat: expected read_data %h error_code %0d",
                             replies_due[i].read_data, replies_due[i].error_code));
    end
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/usbphy_pkg.sv
rtl/usbphy_decode.sv
rtl/usbphy_regs.sv
rtl/usb_phy_register_block.sv
rtl/usbphy_checker.sv
bench/usb_phy_register_block_test.sv
